// ===== hdl/cbwpt_pkg.sv =====
package cbwpt_pkg;

  // Width of the prefetch progress counter.
  localparam int unsigned COUNT_WIDTH = 16;
  // Bits of the bus address that form the rom offset.
  localparam int unsigned ROM_ADDR_BITS = 25;
  // Width of the expected fetch address.
  localparam int unsigned NEXT_W = 26;
  // Bits that index one bit of the counter in the remainder loop.
  localparam int unsigned BIT_W = $clog2(COUNT_WIDTH);
  // Accesses on a 128 KiB boundary are never sequential.
  localparam int unsigned SEQ_BOUNDARY_BITS = 17;

  // First-access waits, selected by a two-bit register code.
  localparam logic [3:0] FIRST_TABLE [4] = '{4'd5, 4'd4, 4'd3, 4'd9};

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ROM0_FIRST = 3'd0,
    REG_ROM1_FIRST = 3'd1,
    REG_ROM2_FIRST = 3'd2,
    REG_SRAM_WAIT  = 3'd3,
    REG_ROM0_FAST  = 3'd4,
    REG_ROM1_FAST  = 3'd5,
    REG_ROM2_FAST  = 3'd6,
    REG_PREFETCH   = 3'd7
  } cfg_idx_e;

  // Operations of the shared add/subtract unit.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e                op;
    logic [COUNT_WIDTH-1:0] a;
    logic [COUNT_WIDTH-1:0] b;
  } alu_req_t;

  // For a subtraction, carry is set when a >= b.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] res;
    logic                   carry;
  } alu_rsp_t;

  // Sequential wait of a rom window.
  function automatic logic [3:0] seq_wait(logic [1:0] win, logic [2:0] fast);
    logic [3:0] s;
    case (win)
      2'd0:    s = fast[0] ? 4'd2 : 4'd3;
      2'd1:    s = fast[1] ? 4'd2 : 4'd5;
      2'd2:    s = fast[2] ? 4'd2 : 4'd9;
      default: s = 4'd2;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/cbwpt_alu.sv =====
module cbwpt_alu (
  input  cbwpt_pkg::alu_req_t req_i,
  output cbwpt_pkg::alu_rsp_t rsp_o
);
  import cbwpt_pkg::*;

  logic                   sub;
  logic [COUNT_WIDTH-1:0] b_eff;
  logic [COUNT_WIDTH:0]   sum;

  // One adder serves both operations; subtraction adds the complement plus one.
  assign sub   = (req_i.op == ALU_SUB);
  assign b_eff = sub ? ~req_i.b : req_i.b;
  assign sum   = {1'b0, req_i.a} + {1'b0, b_eff} + (COUNT_WIDTH + 1)'(sub);

  assign rsp_o.res   = sum[COUNT_WIDTH-1:0];
  assign rsp_o.carry = sum[COUNT_WIDTH];

endmodule

// ===== hdl/cart_bus_wait_prefetch_timer_unit.sv =====
// An accepted access is decoded in S_DECODE and its result beat is loaded in S_DONE; a prefetch
// hit that is served halfword by halfword passes through S_HALF for each halfword, and a cartridge
// data access with prefetch enabled runs the bit-serial remainder loop in S_MOD over the progress
// counter through the one shared add/subtract unit. No new access is taken until the result beat
// is loaded, and a stalled output holds the finished result in S_DONE.
// Reset clears the configuration, the counter and the expected fetch address.
module cart_bus_wait_prefetch_timer_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  cbwpt_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [31:0]          address_i,
  input  logic                 wide_i,
  input  logic                 sequential_i,
  input  logic                 prefetch_paused_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [4:0]           wait_cycles_o
);
  import cbwpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HALF,
    S_MOD,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [1:0]             cfg_first_q [4];
  logic [2:0]             cfg_fast_q;
  logic                   cfg_pf_q;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [NEXT_W-1:0]      next_q, next_d;
  logic                   fvalid_q, fvalid_d;
  logic [4:0]             tot_q, tot_d;
  logic [3:0]             rem_q, rem_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic                   half_q, half_d;
  logic                   out_valid_q, out_valid_d;
  logic [4:0]             wait_q;
  logic                   out_load;

  logic                   cmd_q, wide_q, seq_q, paused_q;
  logic [31:0]            addr_q;

  logic                   accept;
  logic [7:0]             region;
  logic                   is_int, is_high, is_sram;
  logic [1:0]             win;
  logic                   fetch_pf;
  logic [3:0]             s_cur, s_m1, first_cur;
  logic [4:0]             twice_s_m1;
  logic [2:0]             w_int;
  logic                   seq_eff;
  logic [4:0]             base;
  logic [NEXT_W-1:0]      rom_off;
  logic                   hit;
  logic [4:0]             r2;
  logic [3:0]             rem_n;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  cbwpt_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign accept        = in_valid_i && !in_stall_o;
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign wait_cycles_o = wait_q;

  // Decode of the held access.
  assign region   = addr_q[31:24];
  assign is_int   = (region[7:3] == 5'd0);
  assign is_high  = (region[7:4] != 4'd0);
  assign win      = region[2:1];
  assign is_sram  = (win == 2'd3);
  assign fetch_pf = cmd_q && cfg_pf_q;

  assign s_cur      = seq_wait(win, cfg_fast_q);
  assign s_m1       = s_cur - 4'd1;
  assign twice_s_m1 = {s_cur, 1'b0} - 5'd1;
  assign first_cur  = FIRST_TABLE[cfg_first_q[win]];

  // Internal region cost: region 2 is slower, and 16-bit buses double for wide beats.
  always_comb begin
    w_int = (region[2:0] == 3'd2) ? 3'd3 : 3'd1;
    if (wide_q && ((region[2:0] == 3'd2) || (region[2:0] == 3'd5) ||
                   (region[2:0] == 3'd6))) begin
      w_int = {w_int[1:0], 1'b0};
    end
  end

  assign seq_eff = seq_q && (addr_q[SEQ_BOUNDARY_BITS-1:0] != '0);
  assign base    = (seq_eff ? {1'b0, s_cur} : {1'b0, first_cur}) +
                   (wide_q ? {1'b0, s_cur} : 5'd0);
  assign rom_off = NEXT_W'(addr_q[ROM_ADDR_BITS-1:0]);
  assign hit     = fvalid_q && (next_q == rom_off);
  assign r2      = {rem_q, count_q[bit_q]};

  // Operand selection for the shared unit.
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state_q)
      S_DECODE: begin
        if (is_int) begin
          alu_req.op = ALU_ADD;
          alu_req.a  = count_q;
          alu_req.b  = COUNT_WIDTH'(w_int);
        end else begin
          alu_req.op = ALU_SUB;
          alu_req.a  = count_q;
          alu_req.b  = COUNT_WIDTH'(twice_s_m1);
        end
      end
      S_HALF: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = count_q;
        alu_req.b  = COUNT_WIDTH'(s_m1);
      end
      S_MOD: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = COUNT_WIDTH'(r2);
        alu_req.b  = COUNT_WIDTH'(s_cur);
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  assign rem_n = alu_rsp.carry ? alu_rsp.res[3:0] : r2[3:0];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    next_d      = next_q;
    fvalid_d    = fvalid_q;
    tot_d       = tot_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    half_d      = half_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        if (is_int) begin
          tot_d = 5'(w_int);
          if (fetch_pf || !paused_q) begin
            count_d = alu_rsp.carry ? '1 : alu_rsp.res;
          end
        end else if (is_high) begin
          tot_d = 5'd1;
        end else if (is_sram) begin
          tot_d = {1'b0, first_cur};
        end else if (!fetch_pf) begin
          // Cartridge data access; the prefetch penalty needs count mod s.
          tot_d = base;
          if (cfg_pf_q) begin
            rem_d   = 4'd0;
            bit_d   = BIT_W'(COUNT_WIDTH - 1);
            state_d = S_MOD;
          end else begin
            count_d  = '0;
            next_d   = '0;
            fvalid_d = 1'b0;
          end
        end else if (hit) begin
          if (wide_q && alu_rsp.carry) begin
            // Both halfwords are already in the buffer.
            tot_d   = 5'd1;
            count_d = alu_rsp.res;
            next_d  = next_q + NEXT_W'(4);
          end else begin
            tot_d   = 5'd0;
            half_d  = wide_q;
            state_d = S_HALF;
          end
        end else begin
          // Prefetch miss restarts the buffer at this address.
          count_d  = '0;
          tot_d    = {1'b0, first_cur} + (wide_q ? {1'b0, s_cur} : 5'd0);
          next_d   = rom_off + (wide_q ? NEXT_W'(4) : NEXT_W'(2));
          fvalid_d = 1'b1;
        end
      end
      S_HALF: begin
        if (alu_rsp.carry) begin
          tot_d   = tot_q + 5'd1;
          count_d = alu_rsp.res;
        end else begin
          tot_d   = tot_q + {1'b0, s_cur} - {1'b0, count_q[3:0]};
          count_d = '0;
        end
        next_d = next_q + NEXT_W'(2);
        if (half_q) begin
          half_d = 1'b0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MOD: begin
        rem_d = rem_n;
        if (bit_q == '0) begin
          tot_d    = tot_q + ((rem_n == s_m1) ? 5'd1 : 5'd0);
          count_d  = '0;
          next_d   = '0;
          fvalid_d = 1'b0;
          state_d  = S_DONE;
        end else begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_first_q <= '{2'd0, 2'd0, 2'd0, 2'd0};
      cfg_fast_q  <= '0;
      cfg_pf_q    <= 1'b0;
      count_q     <= '0;
      next_q      <= '0;
      fvalid_q    <= 1'b0;
      tot_q       <= '0;
      rem_q       <= '0;
      bit_q       <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_q      <= next_d;
      fvalid_q    <= fvalid_d;
      tot_q       <= tot_d;
      rem_q       <= rem_d;
      bit_q       <= bit_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROM0_FIRST: cfg_first_q[0] <= cfg_wdata_i;
          REG_ROM1_FIRST: cfg_first_q[1] <= cfg_wdata_i;
          REG_ROM2_FIRST: cfg_first_q[2] <= cfg_wdata_i;
          REG_SRAM_WAIT:  cfg_first_q[3] <= cfg_wdata_i;
          REG_ROM0_FAST:  cfg_fast_q[0]  <= cfg_wdata_i[0];
          REG_ROM1_FAST:  cfg_fast_q[1]  <= cfg_wdata_i[0];
          REG_ROM2_FAST:  cfg_fast_q[2]  <= cfg_wdata_i[0];
          REG_PREFETCH:   cfg_pf_q       <= cfg_wdata_i[0];
          default: begin
            cfg_pf_q <= cfg_pf_q;
          end
        endcase
      end
    end
  end

  // Access fields and the result beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      addr_q   <= address_i;
      wide_q   <= wide_i;
      seq_q    <= sequential_i;
      paused_q <= prefetch_paused_i;
    end
    if (out_load) begin
      wait_q <= tot_q;
    end
  end

`ifndef SYNTHESIS
  // An accepted access is decoded in the following cycle.
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DECODE))
    else $error("accepted access not decoded");

  // The partial remainder stays below the sequential wait.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> (rem_q < s_cur))
    else $error("remainder out of range");

  // Halfword service only runs on a valid expected address.
  a_half_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HALF) |-> fvalid_q)
    else $error("halfword service without expected address");

  // A finished result is never dropped while the output is held.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && out_valid_q && out_stall_i |=> (state_q == S_DONE))
    else $error("result left while output stalled");
`endif

endmodule

// ===== tb/tb_cart_bus_wait_prefetch_timer_unit.sv =====
`timescale 1ns / 100ps

module tb_cart_bus_wait_prefetch_timer_unit;
  import cbwpt_pkg::*;

  localparam int unsigned CNT_MAX       = (1 << COUNT_WIDTH) - 1;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          STUCK_LIMIT   = 2000;
  localparam int          RAND_PHASES   = 6;
  localparam int          PHASE_ITEMS   = 250;
  localparam int          BUILD_ITEMS   = 20;

  typedef struct {
    bit          cmd;
    logic [31:0] addr;
    bit          wide;
    bit          seq;
    bit          paused;
  } access_t;

  // One row of the directed plan: either a register write or an access.
  // A typed value of -1 means the expected wait comes from the predictor.
  typedef struct {
    bit         is_cfg;
    cfg_idx_e   idx;
    logic [1:0] val;
    access_t    acc;
    int         typed;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [31:0] address_i;
  logic        wide_i;
  logic        sequential_i;
  logic        prefetch_paused_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [4:0]  wait_cycles_o;

  cart_bus_wait_prefetch_timer_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .address_i        (address_i),
    .wide_i           (wide_i),
    .sequential_i     (sequential_i),
    .prefetch_paused_i(prefetch_paused_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .wait_cycles_o    (wait_cycles_o)
  );

  // Predictor copy of the configuration and the prefetch state.
  logic [1:0]  first_code [4];
  logic [2:0]  fast_seq;
  bit          pf_on;
  int unsigned pf_count;
  logic [25:0] pf_next;
  bit          pf_next_ok;

  logic [4:0]  waits_due [$];
  plan_row_t   plan [$];
  int          errors;
  int          stuck_cycles;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned first_wait(logic [1:0] code);
    case (code)
      2'd0:    return 5;
      2'd1:    return 4;
      2'd2:    return 3;
      default: return 9;
    endcase
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [1:0] v);
    case (idx)
      REG_ROM0_FIRST: first_code[0] = v;
      REG_ROM1_FIRST: first_code[1] = v;
      REG_ROM2_FIRST: first_code[2] = v;
      REG_SRAM_WAIT:  first_code[3] = v;
      REG_ROM0_FAST:  fast_seq[0] = v[0];
      REG_ROM1_FAST:  fast_seq[1] = v[0];
      REG_ROM2_FAST:  fast_seq[2] = v[0];
      default:        pf_on = v[0];
    endcase
  endfunction

  // Works out the wait count of one access and advances the prefetch state.
  function automatic logic [4:0] predict_wait(access_t a);
    logic [7:0]  region;
    logic [1:0]  win;
    logic [25:0] rom;
    int unsigned s;
    int unsigned w;
    int unsigned total;
    bit          eff_seq;
    region  = a.addr[31:24];
    win     = region[2:1];
    total   = 0;
    eff_seq = a.seq;

    // Internal regions feed the counter unless the access is paused and is not a fetch with prefetch on.
    if (region < 8) begin
      w = (region == 8'd2) ? 3 : 1;
      if (a.wide && (region == 8'd2 || region == 8'd5 || region == 8'd6))
        w = 2 * w;
      if (!a.paused || (a.cmd && pf_on))
        pf_count = (pf_count + w > CNT_MAX) ? CNT_MAX : pf_count + w;
      return w[4:0];
    end
    if (region >= 16)
      return 5'd1;
    if (win == 2'd3)
      return 5'(first_wait(first_code[3]));

    case (win)
      2'd0:    s = fast_seq[0] ? 2 : 3;
      2'd1:    s = fast_seq[1] ? 2 : 5;
      default: s = fast_seq[2] ? 2 : 9;
    endcase

    if (!a.cmd || !pf_on) begin
      // Cartridge data access, or a fetch while prefetch is off.
      if (pf_on && (pf_count % s) == s - 1)
        total++;
      pf_next_ok = 1'b0;
      pf_next    = '0;
      pf_count   = 0;
      if (a.addr[16:0] == '0)
        eff_seq = 1'b0;
      total += eff_seq ? s : first_wait(first_code[win]);
      if (a.wide)
        total += s;
    end else begin
      rom = {1'b0, a.addr[24:0]};
      if (pf_next_ok && rom == pf_next) begin
        if (a.wide && pf_count >= 2 * s - 1) begin
          // Whole word already buffered.
          total = 1;
          pf_count = (pf_count >= 2 * s) ? pf_count - 2 * s + 1 : 0;
          pf_next  = pf_next + 26'd4;
        end else begin
          for (int k = 0; k < (a.wide ? 2 : 1); k++) begin
            if (pf_count < s) begin
              total += s - pf_count;
              pf_count = 0;
            end else begin
              total += 1;
              pf_count = pf_count - s + 1;
            end
            pf_next = pf_next + 26'd2;
          end
        end
      end else begin
        // Miss: restart the buffer at this address.
        pf_count   = 0;
        total      = first_wait(first_code[win]);
        pf_next    = rom + 26'd2;
        pf_next_ok = 1'b1;
        if (a.wide) begin
          total  += s;
          pf_next = pf_next + 26'd2;
        end
      end
    end
    return total[4:0];
  endfunction

  function automatic void add_access(bit c, logic [31:0] ad, bit w, bit s, bit p, int typed);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = REG_ROM0_FIRST;
    r.val    = '0;
    r.acc    = '{cmd: c, addr: ad, wide: w, seq: s, paused: p};
    r.typed  = typed;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(cfg_idx_e idx, logic [1:0] v);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = v;
    r.acc    = '{cmd: 1'b0, addr: '0, wide: 1'b0, seq: 1'b0, paused: 1'b0};
    r.typed  = -1;
    plan.push_back(r);
  endfunction

  // Random access, biased toward fetches that continue the prefetch stream.
  function automatic access_t random_access();
    access_t a;
    int      pick;
    pick     = $urandom_range(0, 99);
    a.cmd    = 1'($urandom_range(0, 1));
    a.addr   = $urandom;
    a.wide   = 1'($urandom_range(0, 1));
    a.seq    = 1'($urandom_range(0, 1));
    a.paused = 1'($urandom_range(0, 1));
    if (pick < 40) begin
      a.cmd = 1'b1;
      if (pf_next_ok && !pf_next[25])
        a.addr = {7'($urandom_range(4, 6)), pf_next[24:0]};
      else
        a.addr[31:24] = 8'($urandom_range(8, 13));
    end else if (pick < 65) begin
      a.addr[31:24] = 8'($urandom_range(0, 7));
    end else if (pick < 90) begin
      a.cmd = (pick >= 80);
      a.addr[31:24] = 8'($urandom_range(8, 15));
      if ($urandom_range(0, 3) == 0)
        a.addr[16:0] = '0;
    end
    return a;
  endfunction

  // Presents one access beat and records its expected wait at acceptance.
  task automatic send_access(access_t a, int typed);
    logic [4:0] w;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    cmd_i             <= a.cmd;
    address_i         <= a.addr;
    wide_i            <= a.wide;
    sequential_i      <= a.seq;
    prefetch_paused_i <= a.paused;
    do @(posedge clk_i); while (in_stall_o);
    w = predict_wait(a);
    waits_due.push_back((typed >= 0) ? 5'(typed) : w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (waits_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Caller lowers the write enable after the last write of a batch.
  task automatic write_reg(cfg_idx_e idx, logic [1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    apply_reg(idx, v);
    @(negedge clk_i);
  endtask

  // Receiver stalls in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin : check_results
    logic [4:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (waits_due.size() == 0) begin
        $error("wait_cycles: no beat expected, got %0d", wait_cycles_o);
        errors++;
      end else begin
        want = waits_due.pop_front();
        if (wait_cycles_o !== want) begin
          $error("wait_cycles: expected %0d, got %0d", want, wait_cycles_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("** cart_bus_wait_prefetch_timer_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    access_t    a;
    cfg_idx_e   idx;
    logic [1:0] v;

    errors            = 0;
    stuck_cycles      = 0;
    no_idle           = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_ROM0_FIRST;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    cmd_i             = 1'b0;
    address_i         = '0;
    wide_i            = 1'b0;
    sequential_i      = 1'b0;
    prefetch_paused_i = 1'b0;
    out_stall_i       = 1'b0;
    first_code        = '{2'd0, 2'd0, 2'd0, 2'd0};
    fast_seq          = '0;
    pf_on             = 1'b0;
    pf_count          = 0;
    pf_next           = '0;
    pf_next_ok        = 1'b0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed plan. Typed waits hold for the reset configuration only.
    add_access(1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1);
    add_access(1'b0, 32'h0200_0000, 1'b1, 1'b0, 1'b0, 6);
    add_access(1'b0, 32'h02FF_FFFF, 1'b0, 1'b0, 1'b0, 3);
    add_access(1'b0, 32'h0500_0000, 1'b1, 1'b0, 1'b1, 2);
    add_access(1'b0, 32'h0700_0000, 1'b1, 1'b0, 1'b0, 1);
    add_access(1'b0, 32'h1000_0000, 1'b0, 1'b0, 1'b0, 1);
    add_access(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1);
    add_access(1'b0, 32'h0E00_0000, 1'b0, 1'b0, 1'b0, 5);
    add_access(1'b1, 32'h0F12_3456, 1'b1, 1'b0, 1'b0, 5);
    // A rom access on a 128 KiB boundary is never sequential.
    add_access(1'b0, 32'h0800_0000, 1'b0, 1'b1, 1'b0, 5);
    add_access(1'b0, 32'h0800_0002, 1'b0, 1'b1, 1'b0, 3);
    add_access(1'b0, 32'h0800_0002, 1'b1, 1'b1, 1'b0, 6);
    add_access(1'b0, 32'h0A00_0004, 1'b1, 1'b1, 1'b0, 10);
    add_access(1'b0, 32'h0C00_0006, 1'b1, 1'b1, 1'b0, 18);
    add_access(1'b0, 32'h0D02_0000, 1'b1, 1'b1, 1'b0, 14);
    // With prefetch off a fetch is timed as a data access.
    add_access(1'b1, 32'h09FF_FFFE, 1'b1, 1'b0, 1'b0, 8);
    // Prefetch on: miss, counter build-up, hits of both widths, remainder.
    add_reg(REG_PREFETCH, 2'd1);
    add_access(1'b1, 32'h0800_0100, 1'b0, 1'b0, 1'b0, -1);
    add_access(1'b0, 32'h0200_0000, 1'b1, 1'b0, 1'b0, -1);
    add_access(1'b0, 32'h0400_0000, 1'b1, 1'b0, 1'b1, -1);
    add_access(1'b1, 32'h0800_0102, 1'b0, 1'b1, 1'b0, -1);
    add_access(1'b1, 32'h0800_0104, 1'b1, 1'b1, 1'b0, -1);
    add_access(1'b1, 32'h0200_0000, 1'b1, 1'b0, 1'b1, -1);
    add_access(1'b1, 32'h0800_0108, 1'b1, 1'b1, 1'b0, -1);
    add_access(1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, -1);
    add_access(1'b0, 32'h0800_0200, 1'b0, 1'b1, 1'b0, -1);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
        cfg_we_i <= 1'b0;
      end else begin
        send_access(plan[i].acc, plan[i].typed);
      end
    end

    // Build up a large count, then consume from it.
    settle();
    write_reg(REG_ROM0_FAST, 2'd1);
    cfg_we_i <= 1'b0;
    send_access('{cmd: 1'b1, addr: 32'h0800_0000, wide: 1'b0, seq: 1'b0, paused: 1'b0}, -1);
    repeat (BUILD_ITEMS)
      send_access('{cmd: 1'b0, addr: 32'h0200_0010, wide: 1'b1, seq: 1'b0, paused: 1'b0}, -1);
    send_access('{cmd: 1'b1, addr: 32'h0800_0002, wide: 1'b0, seq: 1'b1, paused: 1'b0}, -1);
    send_access('{cmd: 1'b1, addr: 32'h0800_0004, wide: 1'b1, seq: 1'b1, paused: 1'b0}, -1);
    repeat (BUILD_ITEMS)
      send_access('{cmd: 1'b1, addr: 32'h0200_0020, wide: 1'b1, seq: 1'b0, paused: 1'b1}, -1);
    send_access('{cmd: 1'b0, addr: 32'h0800_0010, wide: 1'b0, seq: 1'b1, paused: 1'b0}, -1);

    // Random phases: reset values, slowest waits, then mixed settings.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      idx = idx.first();
      do begin
        if (ph == 0)
          v = 2'd0;
        else if (ph == 1)
          v = (idx <= REG_SRAM_WAIT) ? 2'd3 : 2'd0;
        else if (ph == 2)
          v = (idx <= REG_SRAM_WAIT) ? 2'd3 : 2'd1;
        else if (idx <= REG_SRAM_WAIT)
          v = 2'($urandom_range(0, 3));
        else
          v = 2'($urandom_range(0, 1));
        if (idx == REG_PREFETCH)
          v = (ph == 0 || ph == RAND_PHASES - 1) ? 2'($urandom_range(0, 1)) : 2'd1;
        write_reg(idx, v);
        idx = idx.next();
      end while (idx != idx.first());
      cfg_we_i <= 1'b0;
      no_idle = (ph == RAND_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2)
          drain();
        a = random_access();
        send_access(a, -1);
      end
    end

    settle();
    if (errors == 0)
      $display("** cart_bus_wait_prefetch_timer_unit: PASSED **");
    else
      $display("** cart_bus_wait_prefetch_timer_unit: FAILED **");
    $finish;
  end

endmodule
